// ===== rtl/stepper_half_step_ramp_controller_assert.svh =====
// assertion macros for the stepper half-step ramp controller checks
`ifndef STEPPER_HALF_STEP_RAMP_CONTROLLER_ASSERT_SVH
`define STEPPER_HALF_STEP_RAMP_CONTROLLER_ASSERT_SVH

// same-cycle implication, off during reset
`define STPHS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stepper controller check failed");

// next-cycle implication, off during reset
`define STPHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stepper controller check failed");

// next-cycle implication that also holds across reset
`define STPHS_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("stepper controller reset check failed");

`endif

// ===== rtl/stphs_pkg.sv =====
// shared types, constants and tables of the stepper half-step ramp controller
package stphs_pkg;

    localparam int ANGLE_W  = 12;
    localparam int STEP_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int COIL_W   = 4;
    localparam int PHASE_W  = 3;

    // stream word layout
    localparam int S_TDATA_W      = 16;
    localparam int S_FORWARD_BIT  = ANGLE_W;
    localparam int M_TDATA_W      = 24;
    localparam int M_PERIOD_LSB   = COIL_W;
    localparam int M_RUNNING_BIT  = COIL_W + PERIOD_W;
    localparam int M_PAD_W        = M_TDATA_W - M_RUNNING_BIT - 1;

    // register file
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST = 1'b1;

    localparam logic [PERIOD_W-1:0] SLOW_RESET   = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] FAST_RESET   = 16'd1250;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TIMER = 1'b1
    } action_t;

    // linear ramp, division by the ramp length done with a scaled reciprocal
    localparam int RAMP_STEPS = 50;
    localparam int RAMP_W     = $clog2(RAMP_STEPS + 1);
    localparam int RAMP_SHIFT = PERIOD_W + 2 * $clog2(RAMP_STEPS) + 1;
    localparam longint unsigned RAMP_RECIP =
        ((64'd1 << RAMP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int RECIP_W = $clog2(RAMP_RECIP + 1);
    localparam int DM_W    = PERIOD_W + RECIP_W;
    localparam int PROD_W  = DM_W + RAMP_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam longint unsigned CEIL_ADD = (RAMP_STEPS - 1) * RAMP_RECIP;
    localparam logic [DM_W-1:0] DM_RESET =
        DM_W'((longint'(SLOW_RESET) - longint'(FAST_RESET)) * RAMP_RECIP);

    typedef struct packed {
        logic [PERIOD_W-1:0] slow;
        logic [PERIOD_W-1:0] fast_eff;
        logic [DM_W-1:0]     dm;
    } ramp_cfg_t;

    // move length: floor(angle * 512 / 45) = quot * 512 + frac(rem)
    localparam int MOVE_DIV    = 45;
    localparam int FRAC_W      = 9;
    localparam int REM_W       = 6;
    localparam int DIV45_W     = 12;
    localparam int DIV45_SHIFT = 17;
    localparam logic [DIV45_W-1:0] DIV45_RECIP = 12'd2913;

    localparam logic [FRAC_W-1:0] ANGLE_FRAC [64] = '{
          0,  11,  22,  34,  45,  56,  68,  79,  91, 102, 113, 125, 136, 147, 159, 170,
        182, 193, 204, 216, 227, 238, 250, 261, 273, 284, 295, 307, 318, 329, 341, 352,
        364, 375, 386, 398, 409, 420, 432, 443, 455, 466, 477, 489, 500,   0,   0,   0,
          0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0,   0
    };

    // half-step coil sequence, bit0 coil a up to bit3 coil d
    localparam logic [COIL_W-1:0] COIL_SEQ [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

endpackage

// ===== rtl/stphs_move_len.sv =====
// move length in half-steps from the requested angle
module stphs_move_len (
    input  logic [stphs_pkg::ANGLE_W-1:0] angle_deg,
    output logic [stphs_pkg::STEP_W-1:0]  steps
);
    import stphs_pkg::*;

    localparam int QP_W = ANGLE_W + DIV45_W;
    localparam int Q_W  = QP_W - DIV45_SHIFT;

    logic [QP_W-1:0]    quot_prod;
    logic [Q_W-1:0]     quot;
    logic [ANGLE_W-1:0] quot_x45;
    logic [REM_W-1:0]   rem;

    assign quot_prod = QP_W'(angle_deg) * QP_W'(DIV45_RECIP);
    assign quot      = quot_prod[QP_W-1:DIV45_SHIFT];
    assign quot_x45  = ANGLE_W'(quot) * ANGLE_W'(MOVE_DIV);
    assign rem       = REM_W'(angle_deg - quot_x45);
    assign steps     = (STEP_W'(quot) << FRAC_W) + STEP_W'(ANGLE_FRAC[rem]);

endmodule

// ===== rtl/stphs_ramp.sv =====
// step period from the linear accelerate, cruise and decelerate ramp
module stphs_ramp (
    input  stphs_pkg::ramp_cfg_t            cfg,
    input  logic [stphs_pkg::STEP_W-1:0]    steps_taken,
    input  logic [stphs_pkg::STEP_W-1:0]    total_steps,
    output logic [stphs_pkg::PERIOD_W-1:0]  period_us
);
    import stphs_pkg::*;

    logic                accel;
    logic                decel;
    logic [STEP_W:0]     k_plus;
    logic [STEP_W:0]     m_full;
    logic [RAMP_W-1:0]   ramp_pos;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    sum;
    logic [PERIOD_W-1:0] delta;
    logic [PERIOD_W-1:0] period_raw;

    assign accel    = steps_taken <= STEP_W'(RAMP_STEPS);
    assign k_plus   = (STEP_W+1)'(steps_taken) + (STEP_W+1)'(RAMP_STEPS);
    assign decel    = k_plus >= (STEP_W+1)'(total_steps);
    assign m_full   = k_plus - (STEP_W+1)'(total_steps);
    assign ramp_pos = accel ? steps_taken[RAMP_W-1:0] : m_full[RAMP_W-1:0];

    // ceil on the way down, floor on the way up
    assign prod  = PROD_W'(cfg.dm) * PROD_W'(ramp_pos);
    assign sum   = SUM_W'(prod) + (accel ? SUM_W'(CEIL_ADD) : SUM_W'(0));
    assign delta = sum[RAMP_SHIFT +: PERIOD_W];

    always_comb begin
        if (accel) begin
            period_raw = cfg.slow - delta;
        end else if (decel) begin
            period_raw = cfg.fast_eff + delta;
        end else begin
            period_raw = cfg.fast_eff;
        end
        period_us = (period_raw == '0) ? PERIOD_W'(1) : period_raw;
    end

endmodule

// ===== rtl/stepper_half_step_ramp_controller.sv =====
// top level of the half-step stepper controller with linear speed ramp
//
// input stream: s_tuser is the action (0 start move, 1 step timer expired),
// s_tdata carries angle_deg and forward; a start computes a move of
// floor(angle*512/45) half-steps, each timer word drives one step pattern.
// output stream: one word per input word with coils, period_us and running;
// m_tlast flags the word that ends a move and releases the coils.
// config channel: cfg_index 0 slow period, 1 fast period, always ready.
// path: input accept goes to the input register, then one pass through the
// step logic and the ramp multiplier into the output register. throughput:
// one word per cycle while m_tready keeps the output moving, set by the single pass
// through the move state update and the ramp multiplier.
// reset: synchronous active-low aresetn clears both stages, the move state,
// and loads slow 65535, fast 1250, held period 1000, coils off.
// stall: a held output word stays stable; the input stage keeps taking
// one more word while the output waits, then s_tready drops.
module stepper_half_step_ramp_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stphs_pkg::S_TDATA_W-1:0]   s_tdata,  // angle_deg[11:0], forward[12], pad
    input  logic                              s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stphs_pkg::M_TDATA_W-1:0]   m_tdata,  // coils[3:0], period_us[19:4], running[20], pad
    output logic                              m_tlast,  // move_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stphs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stphs_pkg::PERIOD_W-1:0]    cfg_wdata
);
    import stphs_pkg::*;

    // config
    logic [PERIOD_W-1:0] fast_reg;
    logic [PERIOD_W-1:0] fast_next;
    logic [PERIOD_W-1:0] slow_next;
    ramp_cfg_t           ramp_cfg_reg;
    ramp_cfg_t           ramp_cfg_next;

    // input stage
    logic                in_valid_reg;
    action_t             in_action_reg;
    logic [ANGLE_W-1:0]  in_angle_reg;
    logic                in_forward_reg;

    // output stage
    logic                out_valid_reg;
    logic [COIL_W-1:0]   out_coils_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic                out_running_reg;
    logic                out_done_reg;

    // move state
    logic [PHASE_W-1:0]  phase_reg,       phase_next;
    logic [STEP_W-1:0]   steps_left_reg,  steps_left_next;
    logic [STEP_W-1:0]   steps_taken_reg, steps_taken_next;
    logic [STEP_W-1:0]   total_steps_reg, total_steps_next;
    logic                direction_reg,   direction_next;
    logic                finishing_reg,   finishing_next;
    logic [COIL_W-1:0]   coil_hold_reg,   coil_hold_next;
    logic [PERIOD_W-1:0] period_hold_reg, period_hold_next;

    logic                s_accept;
    logic                advance;
    logic                busy;
    logic                running;
    logic                move_done;
    logic [STEP_W-1:0]   move_steps;
    logic [STEP_W-1:0]   k_next;
    logic [PERIOD_W-1:0] ramp_period;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        slow_next = ramp_cfg_reg.slow;
        fast_next = fast_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SLOW: slow_next = cfg_wdata;
                CFG_FAST: fast_next = cfg_wdata;
                default: ;
            endcase
        end
        ramp_cfg_next.slow     = slow_next;
        ramp_cfg_next.fast_eff = (fast_next < slow_next) ? fast_next : slow_next;
        ramp_cfg_next.dm       = DM_W'(slow_next - ramp_cfg_next.fast_eff) * DM_W'(RAMP_RECIP);
    end

    stphs_move_len u_move_len (
        .angle_deg (in_angle_reg),
        .steps     (move_steps)
    );

    assign k_next = steps_taken_reg + STEP_W'(1);

    stphs_ramp u_ramp (
        .cfg         (ramp_cfg_reg),
        .steps_taken (k_next),
        .total_steps (total_steps_reg),
        .period_us   (ramp_period)
    );

    assign busy = (steps_left_reg != '0) || finishing_reg;

    always_comb begin
        phase_next       = phase_reg;
        steps_left_next  = steps_left_reg;
        steps_taken_next = steps_taken_reg;
        total_steps_next = total_steps_reg;
        direction_next   = direction_reg;
        finishing_next   = finishing_reg;
        coil_hold_next   = coil_hold_reg;
        period_hold_next = period_hold_reg;
        move_done        = 1'b0;
        if (advance) begin
            case (in_action_reg)
                ACT_START: begin
                    if (!busy && move_steps != '0) begin
                        total_steps_next = move_steps;
                        steps_left_next  = move_steps;
                        steps_taken_next = '0;
                        direction_next   = in_forward_reg;
                        finishing_next   = 1'b0;
                    end
                end
                ACT_TIMER: begin
                    if (finishing_reg) begin
                        finishing_next   = 1'b0;
                        steps_left_next  = '0;
                        steps_taken_next = '0;
                        total_steps_next = '0;
                        coil_hold_next   = '0;
                        move_done        = 1'b1;
                    end else if (steps_left_reg != '0) begin
                        coil_hold_next   = COIL_SEQ[phase_reg];
                        phase_next       = direction_reg ? phase_reg + PHASE_W'(1)
                                                         : phase_reg - PHASE_W'(1);
                        steps_taken_next = k_next;
                        steps_left_next  = steps_left_reg - STEP_W'(1);
                        finishing_next   = (steps_left_reg == STEP_W'(1));
                        period_hold_next = ramp_period;
                    end
                end
                default: ;
            endcase
        end
        running = (steps_left_next != '0) || finishing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg              <= FAST_RESET;
            ramp_cfg_reg.slow     <= SLOW_RESET;
            ramp_cfg_reg.fast_eff <= FAST_RESET;
            ramp_cfg_reg.dm       <= DM_RESET;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            phase_reg             <= '0;
            steps_left_reg        <= '0;
            steps_taken_reg       <= '0;
            total_steps_reg       <= '0;
            direction_reg         <= 1'b0;
            finishing_reg         <= 1'b0;
            coil_hold_reg         <= '0;
            period_hold_reg       <= PERIOD_RESET;
        end else begin
            fast_reg        <= fast_next;
            ramp_cfg_reg    <= ramp_cfg_next;
            in_valid_reg    <= s_accept || (in_valid_reg && !advance);
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            phase_reg       <= phase_next;
            steps_left_reg  <= steps_left_next;
            steps_taken_reg <= steps_taken_next;
            total_steps_reg <= total_steps_next;
            direction_reg   <= direction_next;
            finishing_reg   <= finishing_next;
            coil_hold_reg   <= coil_hold_next;
            period_hold_reg <= period_hold_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg  <= action_t'(s_tuser);
            in_angle_reg   <= s_tdata[ANGLE_W-1:0];
            in_forward_reg <= s_tdata[S_FORWARD_BIT];
        end
        if (advance) begin
            out_coils_reg   <= coil_hold_next;
            out_period_reg  <= period_hold_next;
            out_running_reg <= running;
            out_done_reg    <= move_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_running_reg, out_period_reg, out_coils_reg};
    assign m_tlast  = out_done_reg;

endmodule

// ===== rtl/stphs_checker.sv =====
// port-level checks of the stepper controller, bound to the top level
`include "stepper_half_step_ramp_controller_assert.svh"

module stphs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [stphs_pkg::M_TDATA_W-1:0]   m_tdata,  // coils[3:0], period_us[19:4], running[20], pad
    input logic                              m_tlast   // move_done
);
    import stphs_pkg::*;

    logic [COIL_W-1:0]   m_coils;
    logic [PERIOD_W-1:0] m_period;
    logic                m_running;

    assign m_coils   = m_tdata[COIL_W-1:0];
    assign m_period  = m_tdata[M_PERIOD_LSB +: PERIOD_W];
    assign m_running = m_tdata[M_RUNNING_BIT];

    // stalled word holds
    `STPHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // reset empties both stages
    `STPHS_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid && s_tready)

    // the ending word releases the coils and stops the timer
    `STPHS_ASSERT_SAME(a_done_release, m_tvalid && m_tlast,
        m_coils == '0 && !m_running)

    // the timer never gets a zero period
    `STPHS_ASSERT_SAME(a_period_nonzero, m_tvalid, m_period != '0)

endmodule

bind stepper_half_step_ramp_controller stphs_checker u_stphs_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the half-step stepper controller with linear speed ramp
`timescale 1ns / 1ps

module testbench;
    import stphs_pkg::*;

    localparam longint unsigned RAMP_LEN = RAMP_STEPS;
    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        action_t     action;
        logic [11:0] angle;
        logic        fwd;
    } motor_cmd_t;

    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] period;
        logic        running;
        logic        done;
    } motor_word_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PERIOD_W-1:0]    cfg_wdata;

    stepper_half_step_ramp_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted controller state
    logic [15:0] slow_us;
    logic [15:0] fast_us;
    logic [2:0]  mot_phase;
    logic [15:0] mot_left;
    logic [15:0] mot_taken;
    logic [15:0] mot_total;
    logic        mot_dir;
    logic        mot_finishing;
    logic [3:0]  mot_coils;
    logic [15:0] mot_period;

    motor_cmd_t  cmd_q[$];
    motor_word_t motor_words_due[$];

    int  queued_cnt;
    int  accepted_cnt;
    int  cfg_write_cnt;
    int  words_checked;
    int  moves_ended;
    int  err_cnt;
    logic in_fire;
    logic rst_done;

    int  gap_left;
    int  burst_left;
    int  recv_mode;
    int  recv_mode_left;
    int  recv_stall_left;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic logic [15:0] ramp_period_for(input longint unsigned k,
                                                    input longint unsigned total);
        longint unsigned slow;
        longint unsigned fast;
        longint unsigned d;
        longint unsigned p;
        longint unsigned m;
        longint unsigned rise;
        slow = slow_us;
        fast = (fast_us < slow_us) ? fast_us : slow_us;
        d = slow - fast;
        if (k <= RAMP_LEN) begin
            p = slow - (d * k + RAMP_LEN - 1) / RAMP_LEN;
        end else if (k + RAMP_LEN >= total) begin
            m = k + RAMP_LEN - total;
            rise = (d * m) / RAMP_LEN;
            if (rise > d) rise = d;
            p = fast + rise;
        end else begin
            p = fast;
        end
        if (p == 0) p = 1;
        return p[15:0];
    endfunction

    task automatic predict_word(input motor_cmd_t c);
        motor_word_t w;
        logic        busy;
        int unsigned n;
        busy = (mot_left != 0) || mot_finishing;
        w.done = 1'b0;
        if (c.action == ACT_START) begin
            if (!busy) begin
                n = {20'd0, c.angle} * 512 / 45;
                if (n != 0) begin
                    mot_total = n[15:0];
                    mot_left = n[15:0];
                    mot_taken = '0;
                    mot_dir = c.fwd;
                    mot_finishing = 1'b0;
                end
            end
        end else if (mot_finishing) begin
            mot_finishing = 1'b0;
            mot_left = '0;
            mot_taken = '0;
            mot_total = '0;
            mot_coils = '0;
            w.done = 1'b1;
        end else if (mot_left != 0) begin
            mot_coils = HALF_STEP_COILS[mot_phase];
            mot_phase = mot_dir ? mot_phase + 3'd1 : mot_phase - 3'd1;
            mot_taken = mot_taken + 16'd1;
            mot_left = mot_left - 16'd1;
            if (mot_left == 0) mot_finishing = 1'b1;
            mot_period = ramp_period_for(mot_taken, mot_total);
        end
        w.coils = mot_coils;
        w.period = mot_period;
        w.running = (mot_left != 0) || mot_finishing;
        motor_words_due.push_back(w);
    endtask

    // sampling: input accepts, config writes, output checks
    always @(posedge aclk) begin
        motor_word_t exp_w;
        motor_word_t act_w;
        in_fire <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SLOW) slow_us = cfg_wdata;
                else if (cfg_index == CFG_FAST) fast_us = cfg_wdata;
                cfg_write_cnt = cfg_write_cnt + 1;
            end
            if (s_tvalid && s_tready) begin
                predict_word(motor_cmd_t'{action_t'(s_tuser), s_tdata[11:0],
                                          s_tdata[S_FORWARD_BIT]});
                accepted_cnt = accepted_cnt + 1;
            end
            if (m_tvalid && m_tready) begin
                act_w.coils = m_tdata[3:0];
                act_w.period = m_tdata[M_PERIOD_LSB +: PERIOD_W];
                act_w.running = m_tdata[M_RUNNING_BIT];
                act_w.done = m_tlast;
                if (m_tlast) moves_ended = moves_ended + 1;
                if (motor_words_due.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected word coils=%h period=%0d running=%b done=%b",
                                 $realtime, act_w.coils, act_w.period, act_w.running,
                                 act_w.done);
                end else begin
                    exp_w = motor_words_due.pop_front();
                    words_checked = words_checked + 1;
                    if (act_w !== exp_w) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display("%0t: word %0d exp coils=%h period=%0d running=%b done=%b",
                                     $realtime, words_checked, exp_w.coils, exp_w.period,
                                     exp_w.running, exp_w.done);
                            $display("%0t: word %0d got coils=%h period=%0d running=%b done=%b",
                                     $realtime, words_checked, act_w.coils, act_w.period,
                                     act_w.running, act_w.done);
                        end
                    end
                end
            end
        end
    end

    // command driver, bursts with random gaps
    always @(negedge aclk) begin
        motor_cmd_t nxt;
        if (rst_done && (!s_tvalid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, nxt.fwd, nxt.angle};
                s_tuser <= nxt.action;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with its own stall pattern
    always @(negedge aclk) begin
        if (recv_mode_left <= 0) begin
            recv_mode = $urandom_range(0, 2);
            recv_mode_left = $urandom_range(100, 400);
        end else begin
            recv_mode_left = recv_mode_left - 1;
        end
        if (recv_stall_left > 0) begin
            recv_stall_left = recv_stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            case (recv_mode)
                1: begin
                    if ($urandom_range(0, 3) == 0) recv_stall_left = $urandom_range(1, 3);
                end
                2: begin
                    if ($urandom_range(0, 7) == 0) recv_stall_left = $urandom_range(4, 16);
                end
                default: ;
            endcase
        end
    end

    task automatic push_cmd(input action_t act, input logic [11:0] angle, input logic fwd);
        cmd_q.push_back(motor_cmd_t'{act, angle, fwd});
        queued_cnt = queued_cnt + 1;
    endtask

    task automatic push_timer();
        push_cmd(ACT_TIMER, 12'($urandom), 1'($urandom));
    endtask

    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || motor_words_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        int n0;
        n0 = cfg_write_cnt;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(negedge aclk); while (cfg_write_cnt == n0);
    endtask

    task automatic set_periods(input logic [15:0] slow, input logic [15:0] fast);
        write_reg(CFG_SLOW, slow);
        write_reg(CFG_FAST, fast);
        cfg_valid <= 1'b0;
    endtask

    // whole moves with random content, plus idle timers, zero starts and ignored starts
    task automatic queue_random_moves(input int budget);
        int start_cnt;
        int steps;
        int angle;
        int i;
        start_cnt = queued_cnt;
        while (queued_cnt - start_cnt < budget) begin
            case ($urandom_range(0, 9))
                0: push_timer();
                1: push_cmd(ACT_START, 12'd0, 1'($urandom));
                default: begin
                    angle = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16)
                                                        : $urandom_range(1, 8);
                    steps = angle * 512 / 45;
                    push_cmd(ACT_START, 12'(angle), 1'($urandom));
                    for (i = 0; i <= steps; i++) begin
                        if ($urandom_range(0, 19) == 0)
                            push_cmd(ACT_START, 12'($urandom), 1'($urandom));
                        push_timer();
                    end
                end
            endcase
        end
    endtask

    initial begin
        int i;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_fire = 1'b0;
        rst_done = 1'b0;
        queued_cnt = 0;
        accepted_cnt = 0;
        cfg_write_cnt = 0;
        words_checked = 0;
        moves_ended = 0;
        err_cnt = 0;
        gap_left = 0;
        burst_left = 0;
        recv_mode = 0;
        recv_mode_left = 0;
        recv_stall_left = 0;
        slow_us = SLOW_RESET;
        fast_us = FAST_RESET;
        mot_phase = '0;
        mot_left = '0;
        mot_taken = '0;
        mot_total = '0;
        mot_dir = 1'b0;
        mot_finishing = 1'b0;
        mot_coils = '0;
        mot_period = PERIOD_RESET;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        rst_done <= 1'b1;

        // directed: idle timer, zero move, short forward move with ignored starts
        push_cmd(ACT_TIMER, 12'hFFF, 1'b1);
        push_cmd(ACT_START, 12'd0, 1'b0);
        push_cmd(ACT_START, 12'd1, 1'b1);
        push_cmd(ACT_START, 12'hFFF, 1'b0);
        for (i = 0; i < 11; i++) push_cmd(ACT_TIMER, 12'd0, 1'b0);
        push_cmd(ACT_START, 12'd2, 1'b1);
        push_cmd(ACT_TIMER, 12'd0, 1'b0);
        push_cmd(ACT_TIMER, 12'd0, 1'b0);
        push_cmd(ACT_START, 12'd1, 1'b0);
        push_cmd(ACT_TIMER, 12'hFFF, 1'b1);
        push_cmd(ACT_TIMER, 12'hFFF, 1'b1);
        wait_idle();
        queue_random_moves(120);
        wait_idle();

        set_periods(16'hFFFF, 16'd1);
        queue_random_moves(120);
        wait_idle();

        // fast above slow
        set_periods(16'd1, 16'hFFFF);
        queue_random_moves(120);
        wait_idle();

        set_periods(16'd0, 16'd0);
        queue_random_moves(120);
        wait_idle();

        set_periods(16'd3000, 16'd0);
        queue_random_moves(120);
        wait_idle();

        set_periods(16'($urandom), 16'($urandom));
        queue_random_moves(120);
        wait_idle();

        // longest move, run through the acceleration ramp into cruise
        set_periods(SLOW_RESET, FAST_RESET);
        push_cmd(ACT_START, 12'hFFF, 1'b1);
        for (i = 0; i < 120; i++) push_timer();
        wait_idle();
        repeat (8) @(negedge aclk);

        if (motor_words_due.size() != 0) begin
            err_cnt = err_cnt + motor_words_due.size();
            $display("%0d expected words never arrived", motor_words_due.size());
        end
        $display("checked %0d output words for %0d commands, %0d moves ended",
                 words_checked, accepted_cnt, moves_ended);
        $display("%0d period register writes, %0d mismatches", cfg_write_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout after %0d of %0d commands", accepted_cnt, queued_cnt);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
